FILE: rtl/mrg_pkg.sv
// Shared types and constants for the MRG32k3a generator with skip-ahead.
// Holds moduli, recurrence coefficients, command codes and the control structs.
// No dependencies.
`timescale 1ns / 1ps

package mrg_pkg;

  localparam logic [31:0] M1    = 32'd4294967087;
  localparam logic [31:0] M2    = 32'd4294944443;
  localparam logic [31:0] A12   = 32'd1403580;
  localparam logic [31:0] A13   = 32'd810728;
  localparam logic [31:0] A21   = 32'd527612;
  localparam logic [31:0] A23   = 32'd1370589;
  // 2^32 minus each modulus, used to fold the high word back in
  localparam logic [31:0] FOLD1 = 32'd209;
  localparam logic [31:0] FOLD2 = 32'd22853;

  localparam logic [31:0] SEED_X_RST = 32'd12345;
  localparam logic [31:0] SEED_Y_RST = 32'd12346;
  localparam logic [8:0]  DIMS_RST   = 9'd1;

  localparam int STEP_W        = 48;
  localparam int SKIP_BITS_DEF = 48;

  localparam logic [1:0] REG_SEED_X = 2'd0;
  localparam logic [1:0] REG_SEED_Y = 2'd1;
  localparam logic [1:0] REG_DIMS   = 2'd2;

  typedef enum logic [1:0] {
    CMD_NEXT  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_SKIP  = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    OP_AP,     // accumulated matrix times power matrix
    OP_PP,     // square the power matrix
    OP_APPLY,  // accumulated matrix times history vector
    OP_NEXT    // recurrence row times history vector
  } op_t;

  typedef enum logic [2:0] {
    CM_NONE,
    CM_A,
    CM_P,
    CM_HIST,
    CM_SHIFT
  } cm_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT_WAIT,
    ST_DECIDE,
    ST_MM_SNAP,
    ST_MM_ISSUE,
    ST_MM_WAIT
  } state_t;

  typedef struct packed {
    logic       issue;
    op_t        op;
    logic [1:0] row;
    logic [1:0] col;
    logic       snap;
    cm_t        commit;
    logic       init_mat;
    logic       load_seed;
  } lane_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/mrg_lane.sv
// One recurrence: history, accumulated and power matrices, and a pipelined
// three-wide modular dot-product unit. Depends on mrg_pkg.
`timescale 1ns / 1ps

module mrg_lane #(
  parameter logic [31:0] MOD      = mrg_pkg::M1,
  parameter logic [31:0] FOLD     = mrg_pkg::FOLD1,
  parameter logic [31:0] R0       = 32'd0,
  parameter logic [31:0] R1       = mrg_pkg::A12,
  parameter logic [31:0] R2       = mrg_pkg::M1 - mrg_pkg::A13,
  parameter logic [31:0] HIST_RST = mrg_pkg::SEED_X_RST
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mrg_pkg::lane_cmd_t cmd,
  input  logic [31:0]        seed,
  output logic               busy,
  output logic [31:0]        t00
);
  import mrg_pkg::*;

  logic [31:0] a_r [3][3];
  logic [31:0] p_r [3][3];
  logic [31:0] s_r [3][3];
  logic [31:0] t_r [3][3];
  logic [31:0] h_r [3];

  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [1:0]  r1_r, r2_r, r3_r, r4_r, r5_r;
  logic [1:0]  c1_r, c2_r, c3_r, c4_r, c5_r;
  logic [31:0] a1_r [3];
  logic [31:0] b1_r [3];
  logic [63:0] p2_r [3];
  logic [47:0] f3_r [3];
  logic [31:0] m4_r [3];
  logic [31:0] s5_r, q5_r;

  logic [31:0] row_sel [3];
  logic [31:0] col_sel [3];
  logic [32:0] fold2 [3];

  function automatic logic [31:0] addmod(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD}) begin
      return 32'(s - {1'b0, MOD});
    end
    return s[31:0];
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (cmd.op)
        OP_PP:   row_sel[k] = p_r[cmd.row][k];
        OP_NEXT: row_sel[k] = (k == 0) ? R0 : ((k == 1) ? R1 : R2);
        default: row_sel[k] = a_r[cmd.row][k];
      endcase
      case (cmd.op) inside
        OP_AP, OP_PP: col_sel[k] = s_r[k][cmd.col];
        default:      col_sel[k] = h_r[k];
      endcase
      fold2[k] = 33'(f3_r[k][47:32]) * 33'(FOLD) + 33'(f3_r[k][31:0]);
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    r1_r <= cmd.row;
    c1_r <= cmd.col;
    r2_r <= r1_r;
    c2_r <= c1_r;
    r3_r <= r2_r;
    c3_r <= c2_r;
    r4_r <= r3_r;
    c4_r <= c3_r;
    r5_r <= r4_r;
    c5_r <= c4_r;
    for (int k = 0; k < 3; k++) begin
      a1_r[k] <= row_sel[k];
      b1_r[k] <= col_sel[k];
      p2_r[k] <= 64'(a1_r[k]) * 64'(b1_r[k]);
      f3_r[k] <= 48'(p2_r[k][63:32]) * 48'(FOLD) + 48'(p2_r[k][31:0]);
      m4_r[k] <= (fold2[k] >= {1'b0, MOD}) ? 32'(fold2[k] - {1'b0, MOD})
                                           : fold2[k][31:0];
    end
    s5_r <= addmod(m4_r[0], m4_r[1]);
    q5_r <= m4_r[2];
    if (v5_r) begin
      t_r[r5_r][c5_r] <= addmod(s5_r, q5_r);
    end
  end

  // matrix and history state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) h_r[i] <= HIST_RST;
    end else begin
      if (cmd.load_seed) begin
        for (int i = 0; i < 3; i++) h_r[i] <= seed;
      end
      if (cmd.init_mat) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            a_r[i][j] <= (i == j) ? 32'd1 : 32'd0;
          end
        end
        p_r[0][0] <= R0;
        p_r[0][1] <= R1;
        p_r[0][2] <= R2;
        p_r[1][0] <= 32'd1;
        p_r[1][1] <= 32'd0;
        p_r[1][2] <= 32'd0;
        p_r[2][0] <= 32'd0;
        p_r[2][1] <= 32'd1;
        p_r[2][2] <= 32'd0;
      end
      if (cmd.snap) begin
        s_r <= p_r;
      end
      case (cmd.commit)
        CM_A:    a_r <= t_r;
        CM_P:    p_r <= t_r;
        CM_HIST: begin
          for (int i = 0; i < 3; i++) h_r[i] <= t_r[i][0];
        end
        CM_SHIFT: begin
          // newest word in front, raw older words move down
          h_r[2] <= h_r[1];
          h_r[1] <= h_r[0];
          h_r[0] <= t_r[0][0];
        end
        default: ;
      endcase
    end
  end

  assign busy = v1_r | v2_r | v3_r | v4_r | v5_r;
  assign t00  = t_r[0][0];

endmodule

FILE: rtl/mrg_dp.sv
// Datapath: the two recurrence lanes, the combining subtract and the result
// register. Depends on mrg_pkg and mrg_lane.
`timescale 1ns / 1ps

module mrg_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mrg_pkg::lane_cmd_t  cmd,
  input  logic [31:0]         seed_x,
  input  logic [31:0]         seed_y,
  output mrg_pkg::dp_status_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_uniform_numerator
);
  import mrg_pkg::*;

  logic        busy_x, busy_y;
  logic [31:0] x_val, y_val;
  logic [31:0] z;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;

  mrg_lane #(
    .MOD     (M1),
    .FOLD    (FOLD1),
    .R0      (32'd0),
    .R1      (A12),
    .R2      (M1 - A13),
    .HIST_RST(SEED_X_RST)
  ) u_lane_x (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .seed (seed_x),
    .busy (busy_x),
    .t00  (x_val)
  );

  mrg_lane #(
    .MOD     (M2),
    .FOLD    (FOLD2),
    .R0      (A21),
    .R1      (32'd0),
    .R2      (M2 - A23),
    .HIST_RST(SEED_Y_RST)
  ) u_lane_y (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .seed (seed_y),
    .busy (busy_y),
    .t00  (y_val)
  );

  always_comb begin
    if (x_val > y_val) begin
      z = x_val - y_val;
    end else begin
      z = 32'(33'(x_val) + 33'(M1) - 33'(y_val));
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit == CM_SHIFT) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit == CM_SHIFT) begin
      out_data_r <= z;
    end
  end

  assign stat.busy             = busy_x | busy_y;
  assign stat.out_free         = !out_valid_r || !out_stall;
  assign out_valid             = out_valid_r;
  assign out_uniform_numerator = out_data_r;

  a_shift_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit == CM_SHIFT) |=> out_valid_r)
    else $error("result commit did not load the output register");

endmodule

FILE: rtl/mrg_ctrl.sv
// Controller: command decode, skip-ahead bit walk and matrix op sequencing.
// Depends on mrg_pkg; drives the lane command struct into mrg_dp.
`timescale 1ns / 1ps

module mrg_ctrl #(
  parameter int SKIP_BITS = mrg_pkg::SKIP_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [39:0]         in_path_index,
  input  logic [8:0]          dims,
  input  mrg_pkg::dp_status_t stat,
  output mrg_pkg::lane_cmd_t  cmd
);
  import mrg_pkg::*;

  localparam logic [STEP_W-1:0] STEP_MASK = (SKIP_BITS >= STEP_W) ? {STEP_W{1'b1}} :
    STEP_W'((65'(1) << SKIP_BITS) - 65'(1));

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [1:0]        row_r, row_nxt, col_r, col_nxt;
  logic [STEP_W-1:0] rem_r, rem_nxt;
  logic              nz_r, nz_nxt;
  logic [48:0]       prod;
  logic [STEP_W-1:0] steps;
  logic              last;

  assign prod  = 49'(in_path_index) * 49'(dims);
  assign steps = prod[48:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_AP;
      row_r   <= 2'd0;
      col_r   <= 2'd0;
      rem_r   <= '0;
      nz_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      rem_r   <= rem_nxt;
      nz_r    <= nz_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    rem_nxt       = rem_r;
    nz_nxt        = nz_r;
    cmd.issue     = 1'b0;
    cmd.op        = op_r;
    cmd.row       = row_r;
    cmd.col       = col_r;
    cmd.snap      = 1'b0;
    cmd.commit    = CM_NONE;
    cmd.init_mat  = 1'b0;
    cmd.load_seed = 1'b0;
    last          = (row_r == 2'd2) && (op_r == OP_APPLY || col_r == 2'd2);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd_code_t'(in_command))
            CMD_NEXT: begin
              cmd.issue = 1'b1;
              cmd.op    = OP_NEXT;
              cmd.row   = 2'd0;
              cmd.col   = 2'd0;
              state_nxt = ST_NEXT_WAIT;
            end
            CMD_RESET: cmd.load_seed = 1'b1;
            CMD_SKIP: begin
              cmd.load_seed = 1'b1;
              cmd.init_mat  = 1'b1;
              rem_nxt       = steps & STEP_MASK;
              nz_nxt        = |steps;
              state_nxt     = ST_DECIDE;
            end
            default: ;
          endcase
        end
      end
      ST_NEXT_WAIT: begin
        if (!stat.busy && stat.out_free) begin
          cmd.commit = CM_SHIFT;
          state_nxt  = ST_IDLE;
        end
      end
      ST_DECIDE: begin
        row_nxt = 2'd0;
        col_nxt = 2'd0;
        if (rem_r == '0) begin
          if (nz_r) begin
            op_nxt    = OP_APPLY;
            state_nxt = ST_MM_ISSUE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          op_nxt    = rem_r[0] ? OP_AP : OP_PP;
          state_nxt = ST_MM_SNAP;
        end
      end
      ST_MM_SNAP: begin
        cmd.snap  = 1'b1;
        state_nxt = ST_MM_ISSUE;
      end
      ST_MM_ISSUE: begin
        cmd.issue = 1'b1;
        if (op_r == OP_APPLY || col_r == 2'd2) begin
          col_nxt = 2'd0;
          row_nxt = row_r + 2'd1;
        end else begin
          col_nxt = col_r + 2'd1;
        end
        if (last) begin
          state_nxt = ST_MM_WAIT;
        end
      end
      ST_MM_WAIT: begin
        if (!stat.busy) begin
          unique case (op_r)
            OP_AP: begin
              cmd.commit = CM_A;
              // drop the bit just used; square next if any remain
              rem_nxt    = {rem_r[STEP_W-1:1], 1'b0};
              state_nxt  = ST_DECIDE;
            end
            OP_PP: begin
              cmd.commit = CM_P;
              rem_nxt    = rem_r >> 1;
              state_nxt  = ST_DECIDE;
            end
            default: begin
              cmd.commit = CM_HIST;
              state_nxt  = ST_IDLE;
            end
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit != CM_NONE) |-> !stat.busy)
    else $error("commit while products still in flight");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> in_stall)
    else $error("request accepted while the datapath is busy");

  a_snap_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MM_SNAP) |-> !stat.busy)
    else $error("snapshot taken while the pipe still reads it");

endmodule

FILE: rtl/mrg32k3a_rng_with_skip_ahead_unit.sv
// MRG32k3a generator with skip-ahead, top level.
// Holds the configuration registers; depends on mrg_pkg, mrg_ctrl and mrg_dp.
`timescale 1ns / 1ps

// A next request (command 0) returns z in 1..4294967087; the uniform is
// z / 4294967088. Its products pass the six-stage modular multiply pipeline
// of each recurrence, the two in lockstep, and the result is committed to
// the result register once both pipes drain and the output is free; no new
// request is taken before that. A reset request (command 1) loads the seeds.
// A skip request (command 2) walks floor(path_index*dims/2), masked to
// SKIP_BITS bits, up to the highest set one: each set bit costs a matrix
// product and each bit below the highest a matrix squaring, each product
// being a decide, a snapshot, nine issues and a drain, plus a decide,
// three issues and a drain for applying the result. The user must
// write configuration only while the unit is idle, which it does not enforce.
module mrg32k3a_rng_with_skip_ahead_unit #(
  parameter int SKIP_BITS = mrg_pkg::SKIP_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [39:0] in_path_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_uniform_numerator,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mrg_pkg::*;

  logic [31:0] seed_x_r, seed_y_r;
  logic [8:0]  dims_r;
  lane_cmd_t   cmd;
  dp_status_t  stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_x_r <= SEED_X_RST;
      seed_y_r <= SEED_Y_RST;
      dims_r   <= DIMS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SEED_X: seed_x_r <= cfg_data;
        REG_SEED_Y: seed_y_r <= cfg_data;
        REG_DIMS:   dims_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  mrg_ctrl #(
    .SKIP_BITS(SKIP_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_path_index(in_path_index),
    .dims         (dims_r),
    .stat         (stat),
    .cmd          (cmd)
  );

  mrg_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .seed_x               (seed_x_r),
    .seed_y               (seed_y_r),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_uniform_numerator(out_uniform_numerator)
  );

endmodule
